FILE: hw/rtl/tprd_pkg.sv
`default_nettype none

package tprd_pkg;

    // record content types
    localparam logic [7:0] TYPE_CCS       = 8'd20;
    localparam logic [7:0] TYPE_ALERT     = 8'd21;
    localparam logic [7:0] TYPE_HANDSHAKE = 8'd22;
    localparam logic [7:0] TYPE_APPDATA   = 8'd23;

    // the only legal change-cipher-spec payload
    localparam logic [7:0] CCS_BYTE = 8'h01;

    // error codes
    localparam logic [1:0] ERR_UNKNOWN_TYPE = 2'd0;
    localparam logic [1:0] ERR_TOO_LONG     = 2'd1;
    localparam logic [1:0] ERR_ZERO_LENGTH  = 2'd2;
    localparam logic [1:0] ERR_BAD_CCS      = 2'd3;

    // result kinds
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // configuration register indexes
    localparam logic CFG_IDX_MAX_LEN = 1'b0;
    localparam logic CFG_IDX_SKIP    = 1'b1;

    localparam logic [15:0] MAX_LEN_RESET = 16'd16384;
    localparam logic        SKIP_RESET    = 1'b0;

    // position inside the 5-byte record header, or in the payload
    typedef enum logic [2:0] {
        POS_TYPE,
        POS_VER_HI,
        POS_VER_LO,
        POS_LEN_HI,
        POS_LEN_LO,
        POS_PAYLOAD
    } hdr_pos_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  content_type;
        logic [15:0] record_version;
        logic        last;
        logic [1:0]  error_code;
    } result_t;

    typedef struct packed {
        logic [15:0] max_len;
        logic        skip_load;
        logic        skip_value;
    } cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tprd_parser.sv
`default_nettype none

module tprd_parser
    import tprd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       step,
    input  wire logic [7:0] in_byte,
    output logic            res_valid,
    output result_t         res
);

    hdr_pos_t    pos_reg, pos_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] version_reg, version_next;
    logic [15:0] remaining_reg, remaining_next;
    logic        skip_reg, skip_next;
    logic        ccs_ok_reg, ccs_ok_next;
    logic        error_reg, error_next;

    logic [15:0] hdr_len;
    logic [15:0] rem_dec;
    logic        last;
    logic        skip_app;
    logic        known_type;
    logic        too_long;
    logic        ccs_ok_now;
    logic        active;

    assign active     = step && !error_reg;
    assign hdr_len    = {remaining_reg[15:8], in_byte};
    assign rem_dec    = remaining_reg - 16'd1;
    assign last       = (rem_dec == 16'd0);
    assign skip_app   = skip_reg && (type_reg == TYPE_APPDATA);
    assign known_type = (type_reg == TYPE_CCS) || (type_reg == TYPE_ALERT)
                        || (type_reg == TYPE_HANDSHAKE);
    assign too_long   = (hdr_len > cfg.max_len);
    assign ccs_ok_now = ccs_ok_reg && (in_byte == CCS_BYTE);

    // header position sequencing
    always_comb begin
        pos_next = pos_reg;
        if (active) begin
            case (pos_reg)
                POS_TYPE:   pos_next = POS_VER_HI;
                POS_VER_HI: pos_next = POS_VER_LO;
                POS_VER_LO: pos_next = POS_LEN_HI;
                POS_LEN_HI: pos_next = POS_LEN_LO;
                POS_LEN_LO: begin
                    if (skip_app) begin
                        pos_next = (hdr_len == 16'd0) ? POS_TYPE : POS_PAYLOAD;
                    end else if (known_type && !too_long && hdr_len != 16'd0) begin
                        pos_next = POS_PAYLOAD;
                    end
                end
                POS_PAYLOAD: begin
                    if (last) begin
                        pos_next = POS_TYPE;
                    end
                end
                default: pos_next = POS_TYPE;
            endcase
        end
    end

    // header fields, checks and results
    always_comb begin
        type_next      = type_reg;
        version_next   = version_reg;
        remaining_next = remaining_reg;
        skip_next      = skip_reg;
        ccs_ok_next    = ccs_ok_reg;
        error_next     = error_reg;
        res_valid      = 1'b0;
        res.kind           = KIND_DATA;
        res.data_byte      = in_byte;
        res.content_type   = type_reg;
        res.record_version = version_reg;
        res.last           = last;
        res.error_code     = ERR_UNKNOWN_TYPE;

        if (active) begin
            case (pos_reg)
                POS_TYPE:   type_next = in_byte;
                POS_VER_HI: version_next = {in_byte, 8'h00};
                POS_VER_LO: version_next = {version_reg[15:8], in_byte};
                POS_LEN_HI: remaining_next = {in_byte, 8'h00};
                POS_LEN_LO: begin
                    remaining_next = hdr_len;
                    if (!skip_app) begin
                        if (skip_reg && type_reg != TYPE_CCS) begin
                            skip_next = 1'b0;
                        end
                        if (!known_type) begin
                            res_valid      = 1'b1;
                            res.error_code = ERR_UNKNOWN_TYPE;
                        end else if (too_long) begin
                            res_valid      = 1'b1;
                            res.error_code = ERR_TOO_LONG;
                        end else if (hdr_len == 16'd0) begin
                            res_valid      = 1'b1;
                            res.error_code = ERR_ZERO_LENGTH;
                        end else if (type_reg == TYPE_CCS) begin
                            ccs_ok_next = (hdr_len == 16'd1);
                        end
                        if (res_valid) begin
                            res.kind      = KIND_ERROR;
                            res.data_byte = 8'h00;
                            res.last      = 1'b0;
                            error_next    = 1'b1;
                        end
                    end
                end
                POS_PAYLOAD: begin
                    remaining_next = rem_dec;
                    if (type_reg == TYPE_CCS) begin
                        ccs_ok_next = ccs_ok_now;
                        if (last && !ccs_ok_now) begin
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.data_byte  = 8'h00;
                            res.last       = 1'b0;
                            res.error_code = ERR_BAD_CCS;
                            error_next     = 1'b1;
                        end
                    end else if (type_reg != TYPE_APPDATA) begin
                        res_valid = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // writing the skip register reloads the mode at once
        if (cfg.skip_load) begin
            skip_next = cfg.skip_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= POS_TYPE;
            type_reg      <= 8'h00;
            version_reg   <= 16'h0000;
            remaining_reg <= 16'h0000;
            skip_reg      <= SKIP_RESET;
            ccs_ok_reg    <= 1'b0;
            error_reg     <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            type_reg      <= type_next;
            version_reg   <= version_next;
            remaining_reg <= remaining_next;
            skip_reg      <= skip_next;
            ccs_ok_reg    <= ccs_ok_next;
            error_reg     <= error_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tls_plaintext_record_deframer.sv
// a result from the combinational parse is registered in the result register, or first
//   in the skid register while m_* stalls; throughput: one byte per clock while s_tready
//   is high; the header/payload parse is a single combinational pass over the state
//   registers, followed by a two-entry output buffer (result register plus skid register)
// reset: synchronous active-low aresetn clears the parse state, the sticky
//   error and both output entries; config returns to 16384 / skip off
`default_nettype none

module tls_plaintext_record_deframer
    import tprd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // byte stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte

    // payload bytes and errors out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [7:0] data_byte, [15:8] content_type,
                                        // [31:16] record_version, [33:32] error_code,
                                        // [39:34] zero
    output logic             m_tuser,   // [0] result_kind (0 data, 1 error)
    output logic             m_tlast,   // last payload byte of the record

    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_addr,  // register index
    input  wire logic [15:0] cfg_data
);

    // configuration registers
    logic [15:0] max_len_reg, max_len_next;
    cfg_t        cfg;
    logic        cfg_write;

    // output buffer
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     skid_reg, skid_next;
    logic        out_free;

    // parser interface
    logic        in_xfer;
    logic        res_valid;
    result_t     res;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb begin
        max_len_next = max_len_reg;
        if (cfg_write && cfg_addr == CFG_IDX_MAX_LEN) begin
            max_len_next = cfg_data;
        end
    end

    assign cfg.max_len    = max_len_reg;
    assign cfg.skip_load  = cfg_write && (cfg_addr == CFG_IDX_SKIP);
    assign cfg.skip_value = cfg_data[0];

    // input is held off only while the skid entry is occupied
    assign s_tready = !skid_valid_reg;
    assign in_xfer  = s_tvalid && s_tready;

    tprd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .step      (in_xfer),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                // no transfer this cycle, just move the parked result up
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = res_valid;
                out_next       = res;
            end
        end else if (res_valid) begin
            // output stalled: park the new result
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg    <= MAX_LEN_RESET;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            max_len_reg    <= max_len_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {6'b000000, out_reg.error_code, out_reg.record_version,
                       out_reg.content_type, out_reg.data_byte};

    // the skid entry is only ever filled behind a stalled result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while result register is empty");

    // error results carry no byte and no end-of-record mark
    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ERROR |-> !m_tlast && m_tdata[7:0] == 8'h00)
        else $error("error result with payload byte or last mark");

    // data results come only from alert or handshake records
    a_data_type: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_DATA |->
            (m_tdata[15:8] == TYPE_ALERT || m_tdata[15:8] == TYPE_HANDSHAKE)
            && m_tdata[33:32] == ERR_UNKNOWN_TYPE)
        else $error("data result from a record type that is never forwarded");

endmodule

`default_nettype wire
